// ----- src/aepd_pkg.sv -----
// Shared types and constants for the ATM early packet discard queue.
`default_nettype none

package aepd_pkg;

    localparam int CFG_W       = 11;
    localparam int CFG_IDX_W   = 2;
    localparam int OCC_W       = 11;
    localparam int VC_W        = 8;
    localparam int VCCNT_W     = 9;
    localparam int TAG_W       = 64;
    localparam int VC_SPACE    = 256;
    localparam int CMDQ_DEPTH  = 4;
    localparam int CMDQ_PTR_W  = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W  = $clog2(CMDQ_DEPTH + 1);

    localparam logic [CFG_W-1:0]   RST_THRESHOLD = 11'd600;
    localparam logic [CFG_W-1:0]   RST_LIMIT     = 11'd1000;
    localparam logic [VCCNT_W-1:0] RST_VC_COUNT  = 9'd100;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD = 2'd0,
        CFG_LIMIT     = 2'd1,
        CFG_VC_COUNT  = 2'd2,
        CFG_UNUSED    = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_QUEUED        = 3'd0,
        ST_FRAME_DISCARD = 3'd1,
        ST_OVERFLOW      = 3'd2,
        ST_ILLEGAL_VC    = 3'd3,
        ST_SERVED        = 3'd4,
        ST_EMPTY         = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        FS_CLEAR  = 3'b001,
        FS_IDLE   = 3'b010,
        FS_DECIDE = 3'b100
    } t_front_state;

    typedef struct packed {
        t_status          status;
        logic [OCC_W-1:0] occupancy;
    } t_result;

    typedef struct packed {
        logic    wr;
        logic    rd;
        t_result res;
    } t_cmd_ctl;

endpackage

`default_nettype wire

// ----- src/aepd_front.sv -----
// Front end: accepts requests, runs discard decisions, owns queue pointers.
`default_nettype none

module aepd_front #(
    parameter int BUFFER_DEPTH = 1024,
    parameter int MAX_CHANNELS = 256,
    localparam int PTR_W       = $clog2(BUFFER_DEPTH),
    localparam int CNT_W       = $clog2(BUFFER_DEPTH + 1)
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire  [aepd_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire  [aepd_pkg::CFG_W-1:0]           i_cfg_data,
    input  wire                                  i_valid,
    output logic                                 o_ready,
    input  wire                                  i_req_type,
    input  wire                                  i_is_aal5,
    input  wire  [aepd_pkg::VC_W-1:0]            i_vc_id,
    input  wire                                  i_frame_end,
    input  wire  [aepd_pkg::TAG_W-1:0]           i_cell_tag,
    input  wire                                  i_q_full,
    output logic                                 o_cmd_valid,
    output aepd_pkg::t_cmd_ctl                   o_cmd_ctl,
    output logic [PTR_W-1:0]                     o_cmd_addr,
    output logic [aepd_pkg::TAG_W-1:0]           o_cmd_tag
);

    localparam int FLAG_DEPTH = (MAX_CHANNELS < aepd_pkg::VC_SPACE) ? MAX_CHANNELS
                                                                    : aepd_pkg::VC_SPACE;
    localparam int VC_IDX_W   = $clog2(FLAG_DEPTH);
    localparam int CMP_W      = (CNT_W > aepd_pkg::CFG_W) ? CNT_W : aepd_pkg::CFG_W;
    localparam int START_BIT  = 1;
    localparam int ADMIT_BIT  = 0;

    logic [aepd_pkg::CFG_W-1:0]   r_thr;
    logic [aepd_pkg::CFG_W-1:0]   r_limit;
    logic [aepd_pkg::VCCNT_W-1:0] r_vc_count;
    logic [1:0]                   r_flags [FLAG_DEPTH];
    logic [1:0]                   r_flag_rd;
    logic [1:0]                   n_flag;
    aepd_pkg::t_front_state       r_state, n_state;
    logic [VC_IDX_W-1:0]          r_clr_addr;
    logic                         r_req_type;
    logic                         r_is_aal5;
    logic [aepd_pkg::VC_W-1:0]    r_vc_id;
    logic                         r_frame_end;
    logic [aepd_pkg::TAG_W-1:0]   r_tag;
    logic [PTR_W-1:0]             r_head, n_head;
    logic [PTR_W-1:0]             r_tail, n_tail;
    logic [CNT_W-1:0]             r_count, n_count;

    logic                  accept;
    logic                  decide;
    logic                  flag_we;
    logic                  clr_last;
    logic                  full;
    logic                  below_thr;
    logic                  legal_vc;
    logic                  admit_dec;
    logic [VC_IDX_W-1:0]   rd_idx;
    logic [VC_IDX_W-1:0]   wr_idx;
    logic [CMP_W-1:0]      occ_wide;
    logic [PTR_W-1:0]      tail_inc;
    logic [PTR_W-1:0]      head_inc;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = (r_state == aepd_pkg::FS_IDLE) && !i_q_full;
    assign accept      = i_valid && o_ready;
    assign decide      = (r_state == aepd_pkg::FS_DECIDE);
    assign o_cmd_valid = decide;
    assign o_cmd_tag   = r_tag;

    assign rd_idx    = i_vc_id[VC_IDX_W-1:0];
    assign wr_idx    = r_vc_id[VC_IDX_W-1:0];
    assign clr_last  = (r_clr_addr == VC_IDX_W'(FLAG_DEPTH - 1));
    assign full      = (CMP_W'(r_count) >= CMP_W'(r_limit)) ||
                       (r_count == CNT_W'(BUFFER_DEPTH));
    assign below_thr = CMP_W'(r_count) < CMP_W'(r_thr);
    assign legal_vc  = ({1'b0, r_vc_id} < r_vc_count) &&
                       ({1'b0, r_vc_id} < aepd_pkg::VCCNT_W'(FLAG_DEPTH));
    assign admit_dec = r_flag_rd[START_BIT] ? below_thr : r_flag_rd[ADMIT_BIT];
    assign flag_we   = decide && !r_req_type && r_is_aal5 && legal_vc;
    assign tail_inc  = (r_tail == PTR_W'(BUFFER_DEPTH - 1)) ? '0 : r_tail + PTR_W'(1);
    assign head_inc  = (r_head == PTR_W'(BUFFER_DEPTH - 1)) ? '0 : r_head + PTR_W'(1);

    always_comb begin
        n_flag  = r_flag_rd;
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        o_cmd_ctl.wr         = 1'b0;
        o_cmd_ctl.rd         = 1'b0;
        o_cmd_ctl.res.status = aepd_pkg::ST_QUEUED;
        o_cmd_addr           = r_tail;
        if (r_req_type) begin
            o_cmd_addr = r_head;
            if (r_count == '0) begin
                o_cmd_ctl.res.status = aepd_pkg::ST_EMPTY;
            end else begin
                o_cmd_ctl.rd         = 1'b1;
                o_cmd_ctl.res.status = aepd_pkg::ST_SERVED;
                n_head               = head_inc;
                n_count              = r_count - CNT_W'(1);
            end
        end else if (r_is_aal5 && !legal_vc) begin
            o_cmd_ctl.res.status = aepd_pkg::ST_ILLEGAL_VC;
        end else if (r_is_aal5 && !admit_dec) begin
            o_cmd_ctl.res.status = aepd_pkg::ST_FRAME_DISCARD;
            n_flag               = {r_frame_end, 1'b0};
        end else begin
            if (r_is_aal5) begin
                n_flag = {r_frame_end, !full};
            end
            if (full) begin
                o_cmd_ctl.res.status = aepd_pkg::ST_OVERFLOW;
            end else begin
                o_cmd_ctl.wr = 1'b1;
                n_tail       = tail_inc;
                n_count      = r_count + CNT_W'(1);
            end
        end
        occ_wide                = CMP_W'(n_count);
        o_cmd_ctl.res.occupancy = occ_wide[aepd_pkg::OCC_W-1:0];
    end

    always_comb begin
        case (r_state)
            aepd_pkg::FS_CLEAR:  n_state = clr_last ? aepd_pkg::FS_IDLE : aepd_pkg::FS_CLEAR;
            aepd_pkg::FS_IDLE:   n_state = accept ? aepd_pkg::FS_DECIDE : aepd_pkg::FS_IDLE;
            aepd_pkg::FS_DECIDE: n_state = aepd_pkg::FS_IDLE;
            default:             n_state = aepd_pkg::FS_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr      <= aepd_pkg::RST_THRESHOLD;
            r_limit    <= aepd_pkg::RST_LIMIT;
            r_vc_count <= aepd_pkg::RST_VC_COUNT;
        end else if (i_cfg_valid) begin
            case (aepd_pkg::t_cfg_idx'(i_cfg_index))
                aepd_pkg::CFG_THRESHOLD: r_thr      <= i_cfg_data;
                aepd_pkg::CFG_LIMIT:     r_limit    <= i_cfg_data;
                aepd_pkg::CFG_VC_COUNT:  r_vc_count <= i_cfg_data[aepd_pkg::VCCNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == aepd_pkg::FS_CLEAR) begin
            r_flags[r_clr_addr] <= 2'b11;
        end else if (flag_we) begin
            r_flags[wr_idx] <= n_flag;
        end
        if (accept) begin
            r_flag_rd <= r_flags[rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req_type  <= i_req_type;
            r_is_aal5   <= i_is_aal5;
            r_vc_id     <= i_vc_id;
            r_frame_end <= i_frame_end;
            r_tag       <= i_cell_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= aepd_pkg::FS_CLEAR;
            r_clr_addr <= '0;
            r_head     <= '0;
            r_tail     <= '0;
            r_count    <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == aepd_pkg::FS_CLEAR) begin
                r_clr_addr <= r_clr_addr + VC_IDX_W'(1);
            end
            if (decide) begin
                r_head  <= n_head;
                r_tail  <= n_tail;
                r_count <= n_count;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(BUFFER_DEPTH))
        else $error("queue count beyond depth");

    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("front state not one-hot");

    a_serve_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (decide && o_cmd_ctl.rd) |=> (r_count == $past(r_count) - CNT_W'(1)))
        else $error("serve did not decrement count");

    a_wr_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_ctl.wr |-> (o_cmd_ctl.res.status == aepd_pkg::ST_QUEUED && !o_cmd_ctl.rd))
        else $error("write command without queued status");

    a_empty_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (decide && o_cmd_ctl.res.status == aepd_pkg::ST_EMPTY) |-> (r_count == '0))
        else $error("empty status with cells held");
`endif

endmodule

`default_nettype wire

// ----- src/aepd_cmd_fifo.sv -----
// Short command queue between the decision front end and the storage back end.
`default_nettype none

module aepd_cmd_fifo #(
    parameter int WIDTH = 8
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  wire  [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  wire              i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty
);

    logic [WIDTH-1:0]                    r_mem [aepd_pkg::CMDQ_DEPTH];
    logic [aepd_pkg::CMDQ_PTR_W-1:0]     r_wr_ptr;
    logic [aepd_pkg::CMDQ_PTR_W-1:0]     r_rd_ptr;
    logic [aepd_pkg::CMDQ_CNT_W-1:0]     r_cnt;
    logic                                do_push;
    logic                                do_pop;

    assign o_full  = (r_cnt == aepd_pkg::CMDQ_CNT_W'(aepd_pkg::CMDQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_rdata = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + aepd_pkg::CMDQ_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + aepd_pkg::CMDQ_PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + aepd_pkg::CMDQ_CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - aepd_pkg::CMDQ_CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ----- src/aepd_back.sv -----
// Back end: cell store writes and reads, result output register.
`default_nettype none

module aepd_back #(
    parameter int BUFFER_DEPTH = 1024,
    localparam int PTR_W       = $clog2(BUFFER_DEPTH)
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_q_empty,
    output logic                             o_q_pop,
    input  aepd_pkg::t_cmd_ctl               i_cmd_ctl,
    input  wire  [PTR_W-1:0]                 i_cmd_addr,
    input  wire  [aepd_pkg::TAG_W-1:0]       i_cmd_tag,
    output logic                             o_valid,
    input  wire                              i_ready,
    output aepd_pkg::t_result                o_res,
    output logic                             o_served,
    output logic [aepd_pkg::TAG_W-1:0]       o_cell
);

    logic [aepd_pkg::TAG_W-1:0] r_mem [BUFFER_DEPTH];
    logic [aepd_pkg::TAG_W-1:0] r_rd_data;
    logic                       r_out_valid;
    aepd_pkg::t_result          r_out_res;

    assign o_q_pop  = !i_q_empty && (!r_out_valid || i_ready);
    assign o_valid  = r_out_valid;
    assign o_res    = r_out_res;
    assign o_served = (r_out_res.status == aepd_pkg::ST_SERVED);
    assign o_cell   = o_served ? r_rd_data : '0;

    always_ff @(posedge i_clk) begin
        if (o_q_pop && i_cmd_ctl.wr) begin
            r_mem[i_cmd_addr] <= i_cmd_tag;
        end
        if (o_q_pop && i_cmd_ctl.rd) begin
            r_rd_data <= r_mem[i_cmd_addr];
        end
        if (o_q_pop) begin
            r_out_res <= i_cmd_ctl.res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_q_pop) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

endmodule

`default_nettype wire

// ----- src/atm_early_packet_discard_mux.sv -----
// ATM cell queue with early packet discard for AAL5 frames.
//
// s_axis carries one request per transaction: a cell arrival or a serve.
// m_axis returns exactly one result per request, in request order.
// The cfg channel writes discard threshold, buffer limit and VC count;
// it is always ready and must only be used while no request is in flight.
//
// Path: a request passes the front end request registers, the command queue and the output register to m_axis.
// Flow: no new request is taken until the last is decided; the front end reads
// the per-VC frame flags from a registered memory at the accept edge and
// decides in the next cycle, during which s_axis_tready is low.
// Reset: queue empty, registers at 600, 1000 and 100; the front end then sets
// all per-VC frame flags, one entry per cycle (256 entries with the default
// MAX_CHANNELS), with s_axis_tready low. The cell store is not cleared.
// Stall: a four-entry command queue and the output register absorb results
// while m_axis_tready is low; when the queue fills, s_axis_tready drops until
// the receiver resumes.
`default_nettype none

module atm_early_packet_discard_mux #(
    parameter int BUFFER_DEPTH = 1024,
    parameter int MAX_CHANNELS = 256
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [1:0]  i_cfg_index,
    input  wire  [10:0] i_cfg_data,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [71:0] s_axis_tdata,  // vc_id[7:0], cell_tag[71:8]
    input  wire  [1:0]  s_axis_tuser,  // req_type[0], is_aal5[1]
    input  wire         s_axis_tlast,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [79:0] m_axis_tdata,  // out_cell[63:0], occupancy[74:64], zero[79:75]
    output logic [3:0]  m_axis_tuser   // status[2:0], out_valid[3]
);

    localparam int PTR_W = $clog2(BUFFER_DEPTH);
    localparam int CTL_W = $bits(aepd_pkg::t_cmd_ctl);
    localparam int Q_W   = PTR_W + aepd_pkg::TAG_W + CTL_W;

    logic                       cmd_valid;
    aepd_pkg::t_cmd_ctl         cmd_ctl;
    logic [PTR_W-1:0]           cmd_addr;
    logic [aepd_pkg::TAG_W-1:0] cmd_tag;
    logic                       q_full;
    logic                       q_empty;
    logic                       q_pop;
    logic [Q_W-1:0]             q_wdata;
    logic [Q_W-1:0]             q_rdata;
    aepd_pkg::t_cmd_ctl         q_ctl;
    aepd_pkg::t_result          out_res;
    logic                       out_served;
    logic [aepd_pkg::TAG_W-1:0] out_cell;

    aepd_front #(
        .BUFFER_DEPTH (BUFFER_DEPTH),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_req_type  (s_axis_tuser[0]),
        .i_is_aal5   (s_axis_tuser[1]),
        .i_vc_id     (s_axis_tdata[7:0]),
        .i_frame_end (s_axis_tlast),
        .i_cell_tag  (s_axis_tdata[71:8]),
        .i_q_full    (q_full),
        .o_cmd_valid (cmd_valid),
        .o_cmd_ctl   (cmd_ctl),
        .o_cmd_addr  (cmd_addr),
        .o_cmd_tag   (cmd_tag)
    );

    assign q_wdata = {cmd_addr, cmd_tag, cmd_ctl};

    aepd_cmd_fifo #(
        .WIDTH (Q_W)
    ) u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_valid),
        .i_wdata (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_rdata (q_rdata),
        .o_empty (q_empty)
    );

    assign q_ctl = q_rdata[CTL_W-1:0];

    aepd_back #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (q_empty),
        .o_q_pop    (q_pop),
        .i_cmd_ctl  (q_ctl),
        .i_cmd_addr (q_rdata[Q_W-1 -: PTR_W]),
        .i_cmd_tag  (q_rdata[CTL_W +: aepd_pkg::TAG_W]),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_res      (out_res),
        .o_served   (out_served),
        .o_cell     (out_cell)
    );

    assign m_axis_tdata = {5'd0, out_res.occupancy, out_cell};
    assign m_axis_tuser = {out_served, out_res.status};

endmodule

`default_nettype wire

// ----- test/atm_early_packet_discard_mux_tb.sv -----
// Self-checking testbench for the ATM early packet discard cell queue.
module atm_early_packet_discard_mux_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic REQ_ARRIVE = 1'b0;
    localparam logic REQ_SERVE  = 1'b1;
    localparam int   BUF_CELLS  = 1024;
    localparam int   LONG_HOLD  = 300;

    typedef struct packed {
        logic        kind;
        logic        aal5;
        logic [7:0]  vc;
        logic        last;
        logic [63:0] tag;
    } t_cell_request;

    typedef struct packed {
        aepd_pkg::t_status status;
        logic              valid;
        logic [63:0]       out_tag;
        logic [10:0]       occ;
    } t_cell_verdict;

    class epd_tracker;
        logic [10:0]   threshold;
        logic [10:0]   limit;
        logic [8:0]    vc_limit;
        bit            start_pending [aepd_pkg::VC_SPACE];
        bit            admitted [aepd_pkg::VC_SPACE];
        logic [63:0]   store [BUF_CELLS];
        bit [9:0]      head;
        bit [9:0]      tail;
        bit [10:0]     count;
        t_cell_verdict verdicts_due [$];
        int            errors;

        function new();
            threshold = aepd_pkg::RST_THRESHOLD;
            limit     = aepd_pkg::RST_LIMIT;
            vc_limit  = aepd_pkg::RST_VC_COUNT;
            foreach (start_pending[v]) begin
                start_pending[v] = 1'b1;
                admitted[v]      = 1'b1;
            end
        endfunction

        function void set_reg(aepd_pkg::t_cfg_idx idx, logic [10:0] val);
            case (idx)
                aepd_pkg::CFG_THRESHOLD: threshold = val;
                aepd_pkg::CFG_LIMIT:     limit = val;
                aepd_pkg::CFG_VC_COUNT:  vc_limit = val[8:0];
                default: ;
            endcase
        endfunction

        function bit enqueue(logic [63:0] tag);
            if (count >= ((limit < 11'(BUF_CELLS)) ? limit : 11'(BUF_CELLS)))
                return 1'b0;
            store[tail] = tag;
            tail++;
            count++;
            return 1'b1;
        endfunction

        function void note_request(t_cell_request r);
            t_cell_verdict v;
            v = '0;
            if (r.kind == REQ_SERVE) begin
                if (count == 0) begin
                    v.status = aepd_pkg::ST_EMPTY;
                end else begin
                    v.out_tag = store[head];
                    v.valid   = 1'b1;
                    v.status  = aepd_pkg::ST_SERVED;
                    head++;
                    count--;
                end
            end else if (r.aal5) begin
                if ({1'b0, r.vc} >= vc_limit) begin
                    v.status = aepd_pkg::ST_ILLEGAL_VC;
                end else begin
                    if (start_pending[r.vc]) begin
                        start_pending[r.vc] = 1'b0;
                        admitted[r.vc]      = (count < threshold);
                    end
                    if (r.last)
                        start_pending[r.vc] = 1'b1;
                    if (!admitted[r.vc]) begin
                        v.status = aepd_pkg::ST_FRAME_DISCARD;
                    end else if (enqueue(r.tag)) begin
                        v.status = aepd_pkg::ST_QUEUED;
                    end else begin
                        admitted[r.vc] = 1'b0;
                        v.status       = aepd_pkg::ST_OVERFLOW;
                    end
                end
            end else begin
                v.status = enqueue(r.tag) ? aepd_pkg::ST_QUEUED : aepd_pkg::ST_OVERFLOW;
            end
            v.occ = count;
            verdicts_due.push_back(v);
        endfunction

        function void complain(string what, logic [63:0] want, logic [63:0] seen);
            errors++;
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, what, want, seen);
        endfunction

        function void check_verdict(t_cell_verdict seen);
            t_cell_verdict want;
            if (verdicts_due.size() == 0) begin
                complain("unexpected output, status", '0, seen.status);
                return;
            end
            want = verdicts_due.pop_front();
            if (seen.status !== want.status)
                complain("status", want.status, seen.status);
            if (seen.valid !== want.valid)
                complain("out_valid", want.valid, seen.valid);
            if (seen.out_tag !== want.out_tag)
                complain("out_cell", want.out_tag, seen.out_tag);
            if (seen.occ !== want.occ)
                complain("occupancy", want.occ, seen.occ);
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [10:0] i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;   // vc_id[7:0], cell_tag[71:8]
    logic [1:0]  s_axis_tuser;   // req_type[0], is_aal5[1]
    logic        s_axis_tlast;   // frame_end
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [79:0] m_axis_tdata;   // out_cell[63:0], occupancy[74:64], zero[79:75]
    logic [3:0]  m_axis_tuser;   // status[2:0], out_valid[3]

    epd_tracker tracker;
    int         tx_idle_pct;
    int         rx_idle_pct;
    int         stalls_asked;
    int         stalls_done;

    atm_early_packet_discard_mux u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin : take_output
        t_cell_verdict seen;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen.status  = aepd_pkg::t_status'(m_axis_tuser[2:0]);
            seen.valid   = m_axis_tuser[3];
            seen.out_tag = m_axis_tdata[63:0];
            seen.occ     = m_axis_tdata[74:64];
            tracker.check_verdict(seen);
        end
    end

    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (stalls_done != stalls_asked) begin
                stalls_done++;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    function automatic t_cell_request pack_request(logic kind, logic aal5, logic [7:0] vc,
                                                   logic last, logic [63:0] tag);
        t_cell_request r;
        r.kind = kind;
        r.aal5 = aal5;
        r.vc   = vc;
        r.last = last;
        r.tag  = tag;
        return r;
    endfunction

    function automatic t_cell_request make_request(int serve_pct, int aal5_pct);
        t_cell_request r;
        r.kind = ($urandom_range(99) < serve_pct) ? REQ_SERVE : REQ_ARRIVE;
        r.aal5 = ($urandom_range(99) < aal5_pct);
        r.last = ($urandom_range(3) == 0);
        r.tag  = {$urandom, $urandom};
        case ($urandom_range(9))
            0: r.vc = 8'($urandom);
            1: r.vc = tracker.vc_limit[7:0];
            2: r.vc = 8'(tracker.vc_limit - 9'd1);
            default: r.vc = 8'($urandom_range(5));
        endcase
        return r;
    endfunction

    task automatic send_request(input t_cell_request r);
        if ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= {r.aal5, r.kind};
        s_axis_tlast  <= r.last;
        s_axis_tdata  <= {r.tag, r.vc};
        do @(posedge i_clk); while (!s_axis_tready);
        tracker.note_request(r);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (tracker.verdicts_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apply_setting(input logic [10:0] thr, input logic [10:0] lim,
                                 input logic [8:0] vcs);
        aepd_pkg::t_cfg_idx idx [4];
        logic [10:0]        val [4];
        idx = '{aepd_pkg::CFG_UNUSED, aepd_pkg::CFG_THRESHOLD, aepd_pkg::CFG_LIMIT,
                aepd_pkg::CFG_VC_COUNT};
        val = '{11'($urandom), thr, lim, {2'($urandom), vcs}};
        foreach (idx[j]) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[j];
            i_cfg_data  <= val[j];
            do @(posedge i_clk); while (!o_cfg_ready);
            tracker.set_reg(idx[j], val[j]);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // alternate fill and empty stretches so the queue swings between its limits
    task automatic send_batch(input int n, input int aal5_pct, input int fill_serve,
                              input int empty_serve);
        for (int k = 0; k < n; k++)
            send_request(make_request(((k / 24) % 2 == 0) ? fill_serve : empty_serve,
                                      aal5_pct));
    endtask

    task automatic run_phase(input logic [10:0] thr, input logic [10:0] lim,
                             input logic [8:0] vcs, input int n);
        drain();
        apply_setting(thr, lim, vcs);
        send_batch(n, 60, 20, 65);
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        s_axis_tlast  = 1'b0;
        stalls_asked  = 0;
        stalls_done   = 0;
        tx_idle_pct   = 38;
        rx_idle_pct   = 60;
        tracker       = new();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_request(pack_request(REQ_SERVE, 1'b1, 8'hFF, 1'b1, '1));
        send_request(pack_request(REQ_ARRIVE, 1'b0, 8'hFF, 1'b1, 64'h0));
        send_request(pack_request(REQ_ARRIVE, 1'b0, 8'h00, 1'b0, '1));
        send_request(pack_request(REQ_ARRIVE, 1'b1, 8'd0, 1'b0, 64'h0123_4567_89AB_CDEF));
        send_request(pack_request(REQ_ARRIVE, 1'b1, 8'd0, 1'b1, 64'hFEDC_BA98_7654_3210));
        send_request(pack_request(REQ_ARRIVE, 1'b1, 8'd99, 1'b1, 64'hA5A5_5A5A_A5A5_5A5A));
        send_request(pack_request(REQ_ARRIVE, 1'b1, 8'd100, 1'b0, 64'h1111_2222_3333_4444));
        send_request(pack_request(REQ_ARRIVE, 1'b1, 8'd255, 1'b1, 64'h5555_6666_7777_8888));
        repeat (6) send_request(pack_request(REQ_SERVE, 1'b0, 8'd0, 1'b0, 64'h0));

        drain();
        apply_setting(11'd2, 11'd3, 9'd100);
        send_request(pack_request(REQ_ARRIVE, 1'b1, 8'd1, 1'b0, 64'hA));
        send_request(pack_request(REQ_ARRIVE, 1'b1, 8'd1, 1'b0, 64'hB));
        send_request(pack_request(REQ_ARRIVE, 1'b1, 8'd2, 1'b0, 64'hC));
        send_request(pack_request(REQ_ARRIVE, 1'b1, 8'd2, 1'b1, 64'hD));
        send_request(pack_request(REQ_ARRIVE, 1'b1, 8'd1, 1'b0, 64'hE));
        send_request(pack_request(REQ_ARRIVE, 1'b1, 8'd1, 1'b1, 64'hF));
        send_request(pack_request(REQ_ARRIVE, 1'b0, 8'd7, 1'b0, 64'h10));
        send_request(pack_request(REQ_SERVE, 1'b0, 8'd0, 1'b0, 64'h0));

        run_phase(11'd0, 11'd1024, 9'd511, 90);
        drain();
        apply_setting(11'd4, 11'd8, 9'd1);
        stalls_asked++;
        send_batch(100, 60, 20, 65);

        tx_idle_pct = 60;
        rx_idle_pct = 38;
        run_phase(11'd1, 11'd1, 9'd256, 70);
        run_phase(11'd2047, 11'd0, 9'd0, 40);
        run_phase(11'd12, 11'd20, 9'd8, 45);
        drain();
        send_batch(45, 60, 20, 65);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_phase(11'd6, 11'd10, 9'd4, 70);
        drain();
        apply_setting(11'd1024, 11'd2047, 9'd200);
        send_batch(1150, 40, 1, 1);

        drain();
        if (tracker.errors == 0 && tracker.verdicts_due.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/aepd_pkg.sv
src/aepd_front.sv
src/aepd_cmd_fifo.sv
src/aepd_back.sv
src/atm_early_packet_discard_mux.sv
test/atm_early_packet_discard_mux_tb.sv
